### hw/rtl/lrtp_pkg.sv
// Shared constants, tables and types for the laser range tilt projection unit.
package lrtp_pkg;

  localparam int IDX_W   = 12;
  localparam int MM_W    = 16;
  localparam int START_W = 19;
  localparam int STEP_W  = 16;
  localparam int Q15_W   = 16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ANGLE_START = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_COS_PITCH   = 2'd2;
  localparam logic [1:0] REG_COS_ROLL    = 2'd3;

  localparam int HALF_PI_Q16 = 102944;
  localparam int FULL_Q16    = 4 * HALF_PI_Q16;
  // HALF_PI_Q16 = 2^5 * HALF_ODD; divide by HALF_ODD through a reciprocal
  localparam int HALF_SHIFT  = 5;
  localparam int HALF_ODD    = HALF_PI_Q16 / 32;
  localparam int RECIP_SHIFT = 38;
  localparam logic [26:0] RECIP = 27'd85445418;

  localparam int U_W  = 29;
  localparam int U5_W = U_W - HALF_SHIFT;
  localparam int QH_W = 13;
  localparam int Z_W  = 17;

  localparam int CORDIC_ITERS = 16;
  localparam int XY_W = 33;
  localparam int CZ_W = 20;
  localparam logic signed [XY_W-1:0] CORDIC_K_Q30 = 33'sd652032874;
  localparam logic [15:0] ATAN_Q16 [CORDIC_ITERS] = '{
    16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  localparam logic [Q15_W-1:0] ONE_Q15 = 16'd32768;

  localparam int SQ_W   = 31;
  localparam int F2_W   = 62;
  localparam int F_W    = 31;
  localparam int SQRT_ITERS = 31;
  localparam logic [F2_W-1:0] F2_LIM = 62'd1 << 60;

  typedef struct packed {
    logic [MM_W-1:0] range_mm;
    logic [MM_W-1:0] intensity;
  } side_t;

endpackage

### hw/rtl/lrtp_angle.sv
// Beam angle generation and reduction to quadrant and remainder.
module lrtp_angle (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             valid_in,
  input  lrtp_pkg::side_t                  side_in,
  input  logic [lrtp_pkg::IDX_W-1:0]       beam_index,
  input  logic [lrtp_pkg::START_W-1:0]     angle_start,
  input  logic [lrtp_pkg::STEP_W-1:0]      angle_step,
  output logic                             valid_out,
  output lrtp_pkg::side_t                  side_out,
  output logic [1:0]                       quadrant,
  output logic [lrtp_pkg::Z_W-1:0]         z_out
);

  localparam int P_W = lrtp_pkg::IDX_W + lrtp_pkg::STEP_W;

  logic [2:0]                  vld;
  lrtp_pkg::side_t             side1, side2, side3;
  logic [P_W-1:0]              prod;
  logic [lrtp_pkg::U_W-1:0]    u;
  logic [29:0]                 sum;
  logic [lrtp_pkg::U5_W-1:0]   u5, u5_q;
  logic [4:0]                  ulow_q;
  logic [50:0]                 qmul;
  logic [lrtp_pkg::QH_W-1:0]   qh;
  logic [lrtp_pkg::U5_W-1:0]   r5;

  // Offset by one full turn keeps the sum non-negative without moving the quadrant
  assign sum = {{(30-lrtp_pkg::START_W){angle_start[lrtp_pkg::START_W-1]}}, angle_start}
             + {{(30-P_W){1'b0}}, prod} + 30'(lrtp_pkg::FULL_Q16);
  assign u5   = u[lrtp_pkg::U_W-1:lrtp_pkg::HALF_SHIFT];
  assign qmul = 51'(u5) * 51'(lrtp_pkg::RECIP);
  assign r5   = u5_q - lrtp_pkg::U5_W'(qh) * lrtp_pkg::U5_W'(lrtp_pkg::HALF_ODD);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      valid_out <= 1'b0;
    end else if (en) begin
      vld       <= {vld[1:0], valid_in};
      valid_out <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= P_W'(beam_index) * P_W'(angle_step);
      side1    <= side_in;
      u        <= sum[lrtp_pkg::U_W-1:0];
      side2    <= side1;
      qh       <= qmul[lrtp_pkg::RECIP_SHIFT +: lrtp_pkg::QH_W];
      u5_q     <= u5;
      ulow_q   <= u[4:0];
      side3    <= side2;
      quadrant <= qh[1:0];
      z_out    <= {r5[lrtp_pkg::Z_W-lrtp_pkg::HALF_SHIFT-1:0], ulow_q};
      side_out <= side3;
    end
  end

endmodule

### hw/rtl/lrtp_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage.
module lrtp_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                valid_in,
  input  lrtp_pkg::side_t                     side_in,
  input  logic [1:0]                          quad_in,
  input  logic [lrtp_pkg::Z_W-1:0]            z_in,
  output logic                                valid_out,
  output lrtp_pkg::side_t                     side_out,
  output logic [1:0]                          quad_out,
  output logic signed [lrtp_pkg::XY_W-1:0]    x_out,
  output logic signed [lrtp_pkg::XY_W-1:0]    y_out
);

  localparam int N = lrtp_pkg::CORDIC_ITERS;

  logic                              v_r [N];
  lrtp_pkg::side_t                   s_r [N];
  logic [1:0]                        q_r [N];
  logic signed [lrtp_pkg::XY_W-1:0]  x_r [N];
  logic signed [lrtp_pkg::XY_W-1:0]  y_r [N];
  logic signed [lrtp_pkg::CZ_W-1:0]  z_r [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic                              vi;
    lrtp_pkg::side_t                   si;
    logic [1:0]                        qi;
    logic signed [lrtp_pkg::XY_W-1:0]  xi, yi;
    logic signed [lrtp_pkg::CZ_W-1:0]  zi;

    if (i == 0) begin : g_first
      assign vi = valid_in;
      assign si = side_in;
      assign qi = quad_in;
      assign xi = lrtp_pkg::CORDIC_K_Q30;
      assign yi = '0;
      assign zi = $signed({{(lrtp_pkg::CZ_W-lrtp_pkg::Z_W){1'b0}}, z_in});
    end else begin : g_next
      assign vi = v_r[i-1];
      assign si = s_r[i-1];
      assign qi = q_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i] <= si;
        q_r[i] <= qi;
        if (!zi[lrtp_pkg::CZ_W-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - $signed(lrtp_pkg::CZ_W'(lrtp_pkg::ATAN_Q16[i]));
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + $signed(lrtp_pkg::CZ_W'(lrtp_pkg::ATAN_Q16[i]));
        end
      end
    end
  end

  assign valid_out = v_r[N-1];
  assign side_out  = s_r[N-1];
  assign quad_out  = q_r[N-1];
  assign x_out     = x_r[N-1];
  assign y_out     = y_r[N-1];

endmodule

### hw/rtl/lrtp_gain.sv
// Squared scale factor from beam cosine/sine and platform tilt cosines.
module lrtp_gain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                valid_in,
  input  lrtp_pkg::side_t                     side_in,
  input  logic [1:0]                          quad_in,
  input  logic signed [lrtp_pkg::XY_W-1:0]    x_in,
  input  logic signed [lrtp_pkg::XY_W-1:0]    y_in,
  input  logic [lrtp_pkg::Q15_W-1:0]          cos_pitch,
  input  logic [lrtp_pkg::Q15_W-1:0]          cos_roll,
  output logic                                valid_out,
  output lrtp_pkg::side_t                     side_out,
  output logic [lrtp_pkg::F2_W-1:0]           f2_out
);

  localparam int SQ = lrtp_pkg::SQ_W;
  localparam int PW = 2 * SQ;

  logic [2:0]                    vld;
  lrtp_pkg::side_t               side1, side2, side3;
  logic [lrtp_pkg::Q15_W-1:0]    cx, sy, c, s;
  logic [SQ-1:0]                 c2, s2, cp2, cr2;
  logic [PW-1:0]                 p1, p2;
  logic [PW-1:0]                 f2_sum;

  function automatic logic [lrtp_pkg::Q15_W-1:0] to_q15(
    input logic signed [lrtp_pkg::XY_W-1:0] v
  );
    logic signed [lrtp_pkg::XY_W-1:0] r;
    r = (v + lrtp_pkg::XY_W'(16384)) >>> 15;
    if (r[lrtp_pkg::XY_W-1]) begin
      return '0;
    end else if (r > lrtp_pkg::XY_W'(lrtp_pkg::ONE_Q15)) begin
      return lrtp_pkg::ONE_Q15;
    end else begin
      return r[lrtp_pkg::Q15_W-1:0];
    end
  endfunction

  assign cx     = to_q15(x_in);
  assign sy     = to_q15(y_in);
  assign f2_sum = p1 + p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      valid_out <= 1'b0;
    end else if (en) begin
      vld       <= {vld[1:0], valid_in};
      valid_out <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // odd quadrants swap cos and sin; only their squares matter
      c     <= quad_in[0] ? sy : cx;
      s     <= quad_in[0] ? cx : sy;
      side1 <= side_in;
      c2    <= SQ'(c) * SQ'(c);
      s2    <= SQ'(s) * SQ'(s);
      cp2   <= SQ'(cos_pitch) * SQ'(cos_pitch);
      cr2   <= SQ'(cos_roll) * SQ'(cos_roll);
      side2 <= side1;
      p1    <= PW'(c2) * PW'(cp2);
      p2    <= PW'(s2) * PW'(cr2);
      side3 <= side2;
      f2_out   <= (f2_sum > lrtp_pkg::F2_LIM) ? lrtp_pkg::F2_LIM : f2_sum;
      side_out <= side3;
    end
  end

endmodule

### hw/rtl/lrtp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module lrtp_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  lrtp_pkg::side_t               side_in,
  input  logic [lrtp_pkg::F2_W-1:0]     f2_in,
  output logic                          valid_out,
  output lrtp_pkg::side_t               side_out,
  output logic [lrtp_pkg::F_W-1:0]      f_out
);

  localparam int N = lrtp_pkg::SQRT_ITERS;
  localparam int W = lrtp_pkg::F2_W;

  logic             v_r   [N];
  lrtp_pkg::side_t  s_r   [N];
  logic [W-1:0]     rem_r [N];
  logic [W-1:0]     res_r [N];

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic             vi;
    lrtp_pkg::side_t  si;
    logic [W-1:0]     remi, resi, trial;

    if (k == 0) begin : g_first
      assign vi   = valid_in;
      assign si   = side_in;
      assign remi = f2_in;
      assign resi = '0;
    end else begin : g_next
      assign vi   = v_r[k-1];
      assign si   = s_r[k-1];
      assign remi = rem_r[k-1];
      assign resi = res_r[k-1];
    end

    assign trial = resi + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= si;
        if (remi >= trial) begin
          rem_r[k] <= remi - trial;
          res_r[k] <= (resi >> 1) + BIT;
        end else begin
          rem_r[k] <= remi;
          res_r[k] <= resi >> 1;
        end
      end
    end
  end

  assign valid_out = v_r[N-1];
  assign side_out  = s_r[N-1];
  assign f_out     = res_r[N-1][lrtp_pkg::F_W-1:0];

endmodule

### hw/rtl/laser_range_tilt_projection_unit.sv
// Top level of the laser range tilt projection unit.
// Usage: one laser beam per transfer on the beam channel (beam_valid/beam_stall):
// beam_index, range_mm and intensity. Each beam gives exactly one result on the
// projected channel (proj_valid/proj_stall): projected_mm, the range scaled by the
// tilt factor and truncated, and intensity_out, the input intensity unchanged.
// Configuration (angle_start, angle_step, cos_pitch, cos_roll) is written through
// cfg_we/cfg_index/cfg_data while no beam is in flight; cosines above one saturate.
// The result passes through angle reduction, the CORDIC stages, the squared gain,
// the square root stages and the output register. Throughput is one beam per
// cycle while proj_stall does not hold the pipeline, set by the fully pipelined
// datapath with one CORDIC iteration and one root bit per stage.
// Reset clears all valid bits and loads angle_start = 0, angle_step = 0 and both
// cosines to one. When proj_stall is high with a result waiting, the whole
// pipeline holds and beam_stall rises in the same cycle; nothing is lost or
// repeated, and bubbles travel as invalid stages.
module laser_range_tilt_projection_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            beam_valid,
  output logic                            beam_stall,
  input  logic [lrtp_pkg::IDX_W-1:0]      beam_index,
  input  logic [lrtp_pkg::MM_W-1:0]       range_mm,
  input  logic [lrtp_pkg::MM_W-1:0]       intensity,
  output logic                            proj_valid,
  input  logic                            proj_stall,
  output logic [lrtp_pkg::MM_W-1:0]       projected_mm,
  output logic [lrtp_pkg::MM_W-1:0]       intensity_out,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [lrtp_pkg::START_W-1:0]    cfg_data
);

  logic                                 en;
  logic [lrtp_pkg::START_W-1:0]         angle_start;
  logic [lrtp_pkg::STEP_W-1:0]          angle_step;
  logic [lrtp_pkg::Q15_W-1:0]           cos_pitch, cos_roll, cfg_q15;
  lrtp_pkg::side_t                      side_in, side_a, side_c, side_g, side_s;
  logic                                 v_a, v_c, v_g, v_s;
  logic [1:0]                           quad_a, quad_c;
  logic [lrtp_pkg::Z_W-1:0]             z_a;
  logic signed [lrtp_pkg::XY_W-1:0]     x_c, y_c;
  logic [lrtp_pkg::F2_W-1:0]            f2_g;
  logic [lrtp_pkg::F_W-1:0]             f_s;
  logic [46:0]                          scaled;

  // advance everywhere unless a finished result is held by the receiver
  assign en         = !(proj_valid && proj_stall);
  assign beam_stall = !en;

  assign side_in = '{range_mm: range_mm, intensity: intensity};
  assign cfg_q15 = (cfg_data[lrtp_pkg::Q15_W-1:0] > lrtp_pkg::ONE_Q15)
                 ? lrtp_pkg::ONE_Q15 : cfg_data[lrtp_pkg::Q15_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= '0;
      angle_step  <= '0;
      cos_pitch   <= lrtp_pkg::ONE_Q15;
      cos_roll    <= lrtp_pkg::ONE_Q15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrtp_pkg::REG_ANGLE_START: angle_start <= cfg_data;
        lrtp_pkg::REG_ANGLE_STEP:  angle_step  <= cfg_data[lrtp_pkg::STEP_W-1:0];
        lrtp_pkg::REG_COS_PITCH:   cos_pitch   <= cfg_q15;
        lrtp_pkg::REG_COS_ROLL:    cos_roll    <= cfg_q15;
        default: ;
      endcase
    end
  end

  lrtp_angle u_angle (
    .clk, .rst, .en,
    .valid_in    (beam_valid),
    .side_in     (side_in),
    .beam_index  (beam_index),
    .angle_start (angle_start),
    .angle_step  (angle_step),
    .valid_out   (v_a),
    .side_out    (side_a),
    .quadrant    (quad_a),
    .z_out       (z_a)
  );

  lrtp_cordic u_cordic (
    .clk, .rst, .en,
    .valid_in  (v_a),
    .side_in   (side_a),
    .quad_in   (quad_a),
    .z_in      (z_a),
    .valid_out (v_c),
    .side_out  (side_c),
    .quad_out  (quad_c),
    .x_out     (x_c),
    .y_out     (y_c)
  );

  lrtp_gain u_gain (
    .clk, .rst, .en,
    .valid_in  (v_c),
    .side_in   (side_c),
    .quad_in   (quad_c),
    .x_in      (x_c),
    .y_in      (y_c),
    .cos_pitch (cos_pitch),
    .cos_roll  (cos_roll),
    .valid_out (v_g),
    .side_out  (side_g),
    .f2_out    (f2_g)
  );

  lrtp_isqrt u_isqrt (
    .clk, .rst, .en,
    .valid_in  (v_g),
    .side_in   (side_g),
    .f2_in     (f2_g),
    .valid_out (v_s),
    .side_out  (side_s),
    .f_out     (f_s)
  );

  assign scaled = 47'(side_s.range_mm) * 47'(f_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_valid <= 1'b0;
    end else if (en) begin
      proj_valid <= v_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      projected_mm  <= scaled[30 +: lrtp_pkg::MM_W];
      intensity_out <= side_s.intensity;
    end
  end

endmodule
